[rtl/adc_register_block_assert.svh]
// assertion macros shared by the adc register block rtl
// no dependencies; included by files that carry concurrent assertions
`ifndef ADC_REGISTER_BLOCK_ASSERT_SVH
`define ADC_REGISTER_BLOCK_ASSERT_SVH

// check that is masked while reset is asserted
`define ADC_RB_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that holds on every edge, reset included
`define ADC_RB_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/adc_rb_pkg.sv]
// types and constants of the adc register block
// no dependencies; imported by adc_register_block, adc_register_block_checker and tb_adc_register_block
`timescale 1ns / 1ps
`default_nettype none

package adc_rb_pkg;

  localparam int unsigned NumChannelsDefault = 16;
  localparam int unsigned SampleW            = 12;
  localparam int unsigned RegW               = 32;
  localparam int unsigned ChSelW             = 5;   // channel select width, up to 32 channels
  localparam int unsigned InDataW            = 56;  // offset, write data, channel, sample

  typedef enum logic [1:0] {
    FUNC_READ   = 2'd0,
    FUNC_WRITE  = 2'd1,
    FUNC_SAMPLE = 2'd2
  } func_e;

  // register byte offsets
  localparam logic [7:0] OffStatus  = 8'h00;
  localparam logic [7:0] OffIrqEn   = 8'h04;
  localparam logic [7:0] OffControl = 8'h08;
  localparam logic [7:0] OffConfig  = 8'h0C;
  localparam logic [7:0] OffSmpA    = 8'h10;
  localparam logic [7:0] OffSmpB    = 8'h14;
  localparam logic [7:0] OffChMask  = 8'h28;
  localparam logic [7:0] OffSeq1    = 8'h2C;
  localparam logic [7:0] OffSeq3    = 8'h34;
  localparam logic [7:0] OffDataA   = 8'h40;
  localparam logic [7:0] OffDataB   = 8'h4C;

  // control bits
  localparam int unsigned CtrlEnable   = 0;
  localparam int unsigned CtrlStart    = 2;
  localparam int unsigned CtrlResetCal = 3;
  localparam int unsigned CtrlCal      = 31;

  // status bits
  localparam int unsigned StatReady = 0;
  localparam int unsigned StatEoc   = 1;
  localparam int unsigned StatStart = 2;

  // control bits that never stay set after a write
  localparam logic [RegW-1:0] CtrlSelfClear =
    (RegW'(1) << CtrlCal) | (RegW'(1) << CtrlStart) | (RegW'(1) << CtrlResetCal);

endpackage

`default_nettype wire

[rtl/adc_register_block.sv]
// adc register file serving two register layouts, with sample store
// depends on adc_rb_pkg and adc_register_block_assert.svh
`timescale 1ns / 1ps
`default_nettype none
`include "adc_register_block_assert.svh"

// path: an accepted transaction is held in the input register, then its result in the result register
// throughput: one transaction per cycle while the result stream does not stall, set by the single
// decode and update pass between the input register and the result register
// reset: rst_ni clears the register file, the channel sample store and both valid flags;
// the input and result payload registers are not reset
module adc_register_block
  import adc_rb_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault  // 1 to 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  // input stream
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  // reg_offset[7:0], write_data[39:8], sample_channel[43:40], sample_value[55:44]
  input  wire logic [InDataW-1:0] s_axis_tdata_i,
  // func[1:0]
  input  wire logic [1:0]         s_axis_tuser_i,
  // result stream
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  // read_data[31:0]
  output logic [RegW-1:0]         m_axis_tdata_o
);

  localparam logic [ChSelW:0] NumChLimit = (ChSelW+1)'(NUM_CHANNELS);

  // input register
  logic               in_valid_q, in_valid_d;
  logic [InDataW-1:0] in_data_q;
  logic [1:0]         in_user_q;

  // result register
  logic               out_valid_q, out_valid_d;
  logic [RegW-1:0]    out_data_q, out_data_d;

  // register file
  logic [RegW-1:0] status_q, status_d;
  logic [RegW-1:0] irq_en_q, irq_en_d;
  logic [RegW-1:0] control_q, control_d;
  logic [RegW-1:0] config_q, config_d;
  logic [RegW-1:0] smp_time_q, smp_time_d;
  logic [RegW-1:0] ch_mask_q, ch_mask_d;
  logic [RegW-1:0] seq1_q, seq1_d;
  logic [RegW-1:0] seq3_q, seq3_d;
  logic [RegW-1:0] data_q, data_d;

  // per-channel analog samples
  logic [SampleW-1:0] samples_q [NUM_CHANNELS];

  // decoded fields of the held transaction
  func_e              func;
  logic [7:0]         reg_off;
  logic [RegW-1:0]    wdata;
  logic [3:0]         smp_ch;
  logic [SampleW-1:0] smp_val;

  logic               advance;

  // channel selection for control writes
  logic [ChSelW-1:0]  seq_ch;
  logic               seq_ok;
  logic [ChSelW-1:0]  low_ch;
  logic               low_found;
  logic [ChSelW-1:0]  pick_ch;
  logic [SampleW-1:0] pick_smp;
  logic               take_seq;

  assign func    = func_e'(in_user_q);
  assign reg_off = in_data_q[7:0];
  assign wdata   = in_data_q[39:8];
  assign smp_ch  = in_data_q[43:40];
  assign smp_val = in_data_q[55:44];

  // the held transaction moves on when the result register is free or being drained
  assign advance         = in_valid_q && (!out_valid_q || m_axis_tready_i);
  assign s_axis_tready_o = !in_valid_q || advance;

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;

  // sequence 3 names a channel directly
  assign seq_ch = seq3_q[ChSelW-1:0];
  assign seq_ok = {1'b0, seq_ch} < NumChLimit;

  // lowest channel set in the select mask
  always_comb begin
    low_ch    = '0;
    low_found = 1'b0;
    for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
      if (ch_mask_q[i]) begin
        low_ch    = ChSelW'(i);
        low_found = 1'b1;
      end
    end
  end

  // enable with a valid sequence channel overrides the start sample
  assign take_seq = wdata[CtrlEnable] && seq_ok;
  assign pick_ch  = take_seq ? seq_ch : low_ch;

  always_comb begin
    pick_smp = '0;
    for (int i = 0; i < NUM_CHANNELS; i++) begin
      if (pick_ch == ChSelW'(i)) begin
        pick_smp = samples_q[i];
      end
    end
  end

  // one decode and update pass per transaction
  always_comb begin
    status_d    = status_q;
    irq_en_d    = irq_en_q;
    control_d   = control_q;
    config_d    = config_q;
    smp_time_d  = smp_time_q;
    ch_mask_d   = ch_mask_q;
    seq1_d      = seq1_q;
    seq3_d      = seq3_q;
    data_d      = data_q;
    out_data_d  = out_data_q;
    out_valid_d = out_valid_q;

    if (advance) begin
      out_valid_d = 1'b1;
      out_data_d  = '0;
      case (func)
        FUNC_READ: begin
          case (reg_off)
            OffStatus:  out_data_d = status_q;
            OffIrqEn:   out_data_d = irq_en_q;
            OffControl: out_data_d = control_q;
            OffConfig:  out_data_d = config_q;
            OffSmpA,
            OffSmpB:    out_data_d = smp_time_q;
            OffChMask:  out_data_d = ch_mask_q;
            OffSeq1:    out_data_d = seq1_q;
            OffSeq3:    out_data_d = seq3_q;
            OffDataA:   out_data_d = data_q;
            OffDataB: begin
              out_data_d         = data_q;
              status_d[StatEoc]  = 1'b0;  // reading the second data offset clears eoc
            end
            default:    out_data_d = '0;
          endcase
        end
        FUNC_WRITE: begin
          case (reg_off)
            OffStatus:  status_d   = status_q & ~wdata;  // write one to clear
            OffIrqEn:   irq_en_d   = wdata;
            OffControl: begin
              control_d = wdata & ~CtrlSelfClear;
              if (wdata[CtrlEnable]) begin
                status_d[StatReady] = 1'b1;
                status_d[StatEoc]   = 1'b1;
              end
              if (wdata[CtrlStart]) begin
                status_d[StatStart] = 1'b1;
              end
              if (take_seq || (wdata[CtrlStart] && low_found)) begin
                data_d = RegW'(pick_smp);
              end
            end
            OffConfig:  config_d   = wdata;
            OffSmpA,
            OffSmpB:    smp_time_d = wdata;
            OffChMask:  ch_mask_d  = wdata;
            OffSeq1:    seq1_d     = wdata;
            OffSeq3:    seq3_d     = wdata;
            default:    ;  // unmapped and read-only offsets ignore writes
          endcase
        end
        FUNC_SAMPLE: ;  // sample store is updated below
        default:     ;  // unused code, zero result
      endcase
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign in_valid_d = (s_axis_tvalid_i && s_axis_tready_o) || (in_valid_q && !advance);

  // input register payload
  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid_i && s_axis_tready_o) begin
      in_data_q <= s_axis_tdata_i;
      in_user_q <= s_axis_tuser_i;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  // control and register file
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      status_q    <= '0;
      irq_en_q    <= '0;
      control_q   <= '0;
      config_q    <= '0;
      smp_time_q  <= '0;
      ch_mask_q   <= '0;
      seq1_q      <= '0;
      seq3_q      <= '0;
      data_q      <= '0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      status_q    <= status_d;
      irq_en_q    <= irq_en_d;
      control_q   <= control_d;
      config_q    <= config_d;
      smp_time_q  <= smp_time_d;
      ch_mask_q   <= ch_mask_d;
      seq1_q      <= seq1_d;
      seq3_q      <= seq3_d;
      data_q      <= data_d;
    end
  end

  // sample store; loads to channels at or above the channel count match no entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        samples_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        if (advance && (func == FUNC_SAMPLE) && ({1'b0, smp_ch} == ChSelW'(i))) begin
          samples_q[i] <= smp_val;
        end
      end
    end
  end

  // assertions
  `ADC_RB_ASSERT(a_ctrl_self_clear, clk_i, rst_ni, (control_q & CtrlSelfClear) == '0,
    "self-clearing control bit left set")
  `ADC_RB_ASSERT(a_non_read_zero, clk_i, rst_ni,
    advance && (func != FUNC_READ) |=> out_data_q == '0,
    "non-read transaction gave a nonzero result")
  `ADC_RB_ASSERT(a_data_b_clears_eoc, clk_i, rst_ni,
    advance && (func == FUNC_READ) && (reg_off == OffDataB) |=> !status_q[StatEoc],
    "second data read did not clear eoc")
  `ADC_RB_ASSERT(a_enable_sets_ready, clk_i, rst_ni,
    advance && (func == FUNC_WRITE) && (reg_off == OffControl) && wdata[CtrlEnable]
      |=> status_q[StatReady] && status_q[StatEoc],
    "enable write did not raise ready and eoc")
  `ADC_RB_ASSERT(a_held_item_kept, clk_i, rst_ni,
    in_valid_q && !advance |=> in_valid_q && $stable(in_data_q) && $stable(in_user_q),
    "held transaction lost before it moved on")

endmodule

`default_nettype wire

[verif/adc_register_block_checker.sv]
// scoreboard for the adc register block: mirrors the register file and sample store
// depends on adc_rb_pkg; instantiated next to the block by tb_adc_register_block
`timescale 1ns / 1ps

module adc_register_block_checker
  import adc_rb_pkg::*;
#(
  parameter int unsigned NUM_CHANNELS = NumChannelsDefault
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [InDataW-1:0] in_data_i,
  input  logic [1:0]         in_user_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic [RegW-1:0]    out_data_i,
  output int                 mismatch_count_o,
  output int                 outstanding_o,
  output int                 result_count_o
);

  localparam int MaxReports = 20;

  // packed so that the offset sits in the lowest bits, as on the bus
  typedef struct packed {
    logic [SampleW-1:0] value;
    logic [3:0]         channel;
    logic [RegW-1:0]    wdata;
    logic [7:0]         offset;
  } access_t;

  logic [RegW-1:0]    status_q, irq_en_q, ctrl_q, cfg_q, smp_time_q;
  logic [RegW-1:0]    ch_mask_q, seq1_q, seq3_q, conv_data_q;
  logic [SampleW-1:0] ch_sample_q [NUM_CHANNELS];
  logic [RegW-1:0]    expected_read_data [$];

  task automatic apply_control_write(input logic [RegW-1:0] value);
    int          ch;
    bit          found;
    logic [4:0]  seq_ch;
    ctrl_q = value;
    ctrl_q[CtrlCal] = 1'b0;
    if (ctrl_q[CtrlEnable]) status_q[StatReady] = 1'b1;
    if (ctrl_q[CtrlStart]) begin
      found = 1'b0;
      for (ch = 0; ch < NUM_CHANNELS; ch++) begin
        if (!found && ch_mask_q[ch]) begin
          conv_data_q = RegW'(ch_sample_q[ch]);
          found = 1'b1;
        end
      end
      // empty mask keeps the data word but still flags the start
      status_q[StatStart] = 1'b1;
      ctrl_q[CtrlStart] = 1'b0;
    end
    ctrl_q[CtrlResetCal] = 1'b0;
    if (ctrl_q[CtrlEnable]) begin
      status_q[StatEoc] = 1'b1;
      seq_ch = seq3_q[4:0];
      if (seq_ch < NUM_CHANNELS) conv_data_q = RegW'(ch_sample_q[seq_ch]);
    end
  endtask

  task automatic predict_access(input logic [1:0] fn, input access_t acc,
                                output logic [RegW-1:0] read_data);
    read_data = '0;
    case (fn)
      FUNC_READ: begin
        case (acc.offset)
          OffStatus:         read_data = status_q;
          OffIrqEn:          read_data = irq_en_q;
          OffControl:        read_data = ctrl_q;
          OffConfig:         read_data = cfg_q;
          OffSmpA, OffSmpB:  read_data = smp_time_q;
          OffChMask:         read_data = ch_mask_q;
          OffSeq1:           read_data = seq1_q;
          OffSeq3:           read_data = seq3_q;
          OffDataA:          read_data = conv_data_q;
          OffDataB: begin
            read_data = conv_data_q;
            status_q[StatEoc] = 1'b0;
          end
          default:           read_data = '0;
        endcase
      end
      FUNC_WRITE: begin
        case (acc.offset)
          OffStatus:         status_q = status_q & ~acc.wdata;
          OffIrqEn:          irq_en_q = acc.wdata;
          OffControl:        apply_control_write(acc.wdata);
          OffConfig:         cfg_q = acc.wdata;
          OffSmpA, OffSmpB:  smp_time_q = acc.wdata;
          OffChMask:         ch_mask_q = acc.wdata;
          OffSeq1:           seq1_q = acc.wdata;
          OffSeq3:           seq3_q = acc.wdata;
          default:           ;
        endcase
      end
      FUNC_SAMPLE: begin
        if (acc.channel < NUM_CHANNELS) ch_sample_q[acc.channel] = acc.value;
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    logic [RegW-1:0] exp_data;
    if (!rst_ni) begin
      status_q    = '0;
      irq_en_q    = '0;
      ctrl_q      = '0;
      cfg_q       = '0;
      smp_time_q  = '0;
      ch_mask_q   = '0;
      seq1_q      = '0;
      seq3_q      = '0;
      conv_data_q = '0;
      for (int i = 0; i < NUM_CHANNELS; i++) ch_sample_q[i] = '0;
      expected_read_data.delete();
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
      result_count_o   <= 0;
    end else begin
      // results first, so a transaction can never be matched against itself
      if (out_valid_i && out_ready_i) begin
        result_count_o <= result_count_o + 1;
        if (expected_read_data.size() == 0) begin
          if (mismatch_count_o < MaxReports)
            $display("%0t: unexpected result, expected none, actual %h", $time, out_data_i);
          mismatch_count_o <= mismatch_count_o + 1;
        end else begin
          exp_data = expected_read_data.pop_front();
          if (out_data_i !== exp_data) begin
            if (mismatch_count_o < MaxReports)
              $display("%0t: read_data mismatch, expected %h, actual %h",
                       $time, exp_data, out_data_i);
            mismatch_count_o <= mismatch_count_o + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        predict_access(in_user_i, access_t'(in_data_i), exp_data);
        expected_read_data.push_back(exp_data);
      end
      outstanding_o <= expected_read_data.size();
    end
  end

endmodule

[verif/tb_adc_register_block.sv]
// top of the adc register block testbench: clock, reset, traffic and verdict
// depends on adc_rb_pkg, adc_register_block and adc_register_block_checker
`timescale 1ns / 1ps

module tb_adc_register_block;
  import adc_rb_pkg::*;

  // func code 3 is not decoded by the block and must read back as zero
  localparam logic [1:0] FuncUnused = 2'd3;

  localparam int RandomAccesses = 1125;
  localparam int HoldOffCycles  = 150;   // long receiver stall to back up the pipe
  localparam int DrainCycles    = 8;     // edges waited after the final drain before the verdict
  localparam int CycleLimit     = 200000;

  // control bits that carry side effects, used to bias control writes
  localparam logic [RegW-1:0] CtrlActionBits =
    (RegW'(1) << CtrlEnable) | (RegW'(1) << CtrlStart) |
    (RegW'(1) << CtrlResetCal) | (RegW'(1) << CtrlCal);

  logic               clk_i    = 1'b0;
  logic               rst_ni   = 1'b0;
  logic               s_tvalid = 1'b0;
  logic [InDataW-1:0] s_tdata  = '0;
  logic [1:0]         s_tuser  = '0;
  logic               m_tready = 1'b0;
  logic               s_tready;
  logic               m_tvalid;
  logic [RegW-1:0]    m_tdata;

  int mismatches;
  int outstanding;
  int results;

  // traffic statistics for the closing summary
  int reads_sent, writes_sent, loads_sent, unused_sent;

  // hold-off request: the receiver starts a long stall whenever this changes
  int hold_seq  = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int rx_mode   = 0;
  int rx_left   = 0;
  int cycle_count = 0;

  always #6 clk_i = ~clk_i;

  adc_register_block #(
    .NUM_CHANNELS    (NumChannelsDefault)
  ) i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),   // reg_offset, write_data, sample_channel, sample_value
    .s_axis_tuser_i  (s_tuser),   // func
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata)    // read_data
  );

  adc_register_block_checker #(
    .NUM_CHANNELS     (NumChannelsDefault)
  ) i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (s_tvalid),
    .in_ready_i       (s_tready),
    .in_data_i        (s_tdata),
    .in_user_i        (s_tuser),
    .out_valid_i      (m_tvalid),
    .out_ready_i      (m_tready),
    .out_data_i       (m_tdata),
    .mismatch_count_o (mismatches),
    .outstanding_o    (outstanding),
    .result_count_o   (results)
  );

  // watchdog: generous bound on the slowest legal run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("run exceeded %0d cycles", CycleLimit);
      $display("Some tests failed");
      $finish;
    end
  end

  // result side: stall pattern changes every so often, with one long hold-off
  always @(posedge clk_i) begin
    if (hold_seq != hold_seen) begin
      hold_seen <= hold_seq;
      hold_left <= HoldOffCycles;
      m_tready  <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready  <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode <= $urandom_range(0, 3);
        rx_left <= $urandom_range(32, 200);
      end else begin
        rx_left <= rx_left - 1;
      end
      case (rx_mode)
        0:       m_tready <= 1'b1;                          // no stalls at all
        1:       m_tready <= $urandom_range(0, 1);          // heavy random stalls
        2:       m_tready <= ($urandom_range(0, 99) < 85);  // light random stalls
        default: m_tready <= (cycle_count[1:0] != 2'd0);    // ready except when the cycle count is a multiple of four
      endcase
    end
  end

  // offer one transaction and hold it until the block takes it
  task automatic send_item(input logic [1:0] fn, input logic [7:0] off,
                           input logic [RegW-1:0] wdata, input logic [3:0] ch,
                           input logic [SampleW-1:0] value);
    s_tvalid <= 1'b1;
    s_tdata  <= {value, ch, wdata, off};
    s_tuser  <= fn;
    do @(posedge clk_i); while (!s_tready);
    case (fn)
      FUNC_READ:   reads_sent++;
      FUNC_WRITE:  writes_sent++;
      FUNC_SAMPLE: loads_sent++;
      default:     unused_sent++;
    endcase
  endtask

  task automatic reg_rd(input logic [7:0] off);
    send_item(FUNC_READ, off, '0, '0, '0);
  endtask

  task automatic reg_wr(input logic [7:0] off, input logic [RegW-1:0] wdata);
    send_item(FUNC_WRITE, off, wdata, '0, '0);
  endtask

  task automatic load_sample(input logic [3:0] ch, input logic [SampleW-1:0] value);
    send_item(FUNC_SAMPLE, '0, '0, ch, value);
  endtask

  task automatic idle(input int cycles);
    s_tvalid <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // stop offering and wait until every predicted result has come back;
  // the extra edge lets the checker count the last accepted transaction
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] mapped_offset();
    case ($urandom_range(0, 10))
      0:       return OffStatus;
      1:       return OffIrqEn;
      2:       return OffControl;
      3:       return OffConfig;
      4:       return OffSmpA;
      5:       return OffSmpB;
      6:       return OffChMask;
      7:       return OffSeq1;
      8:       return OffSeq3;
      9:       return OffDataA;
      default: return OffDataB;
    endcase
  endfunction

  // mostly mapped registers; control, status and mask writes are biased
  // toward values that exercise their side effects
  task automatic send_random_access();
    int              pick;
    logic [1:0]      fn;
    logic [7:0]      off;
    logic [RegW-1:0] wdata;
    pick = $urandom_range(0, 99);
    if (pick < 38)      fn = FUNC_READ;
    else if (pick < 72) fn = FUNC_WRITE;
    else if (pick < 95) fn = FUNC_SAMPLE;
    else                fn = FuncUnused;
    off   = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255)) : mapped_offset();
    wdata = $urandom;
    if (fn == FUNC_WRITE) begin
      case (off)
        OffControl: begin
          if ($urandom_range(0, 1)) wdata = wdata & CtrlActionBits;
        end
        OffStatus: begin
          if ($urandom_range(0, 1)) wdata = RegW'(1) << $urandom_range(StatReady, StatStart);
        end
        OffChMask: begin
          case ($urandom_range(0, 2))
            0:       wdata = '0;
            1:       wdata = RegW'(1) << $urandom_range(0, 31);
            default: ;
          endcase
        end
        default: ;
      endcase
    end
    send_item(fn, off, wdata, 4'($urandom_range(0, 15)), 12'($urandom_range(0, 4095)));
  endtask

  initial begin
    int sent;
    int burst;
    bit held;
    bit paused;
    sent   = 0;
    held   = 1'b0;
    paused = 1'b0;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: reset values, sample extremes, start and enable paths
    reg_rd(OffStatus);
    load_sample(4'd0, 12'hFFF);
    load_sample(4'd5, 12'hABC);
    load_sample(4'd15, 12'h801);
    reg_wr(OffChMask, 32'h0000_0020);
    reg_wr(OffControl, 32'h0000_0004);        // start picks channel 5
    reg_rd(OffDataA);
    reg_wr(OffSeq3, 32'h0000_001F);           // sequence channel out of range
    reg_wr(OffControl, 32'h8000_0009);        // enable with both calibration bits
    reg_rd(OffControl);
    reg_rd(OffDataB);                         // clears end of conversion
    reg_rd(OffStatus);
    reg_wr(OffStatus, 32'hFFFF_FFFF);         // write one to clear everything
    reg_wr(OffChMask, 32'h0000_0000);
    reg_wr(OffSeq3, 32'hFFFF_FFEF);           // sequence channel 15
    reg_wr(OffControl, 32'hFFFF_FFFF);        // start with empty mask plus enable
    reg_rd(OffDataA);
    reg_wr(OffDataA, 32'hFFFF_FFFF);          // data offsets are read only
    reg_wr(8'hFF, 32'hFFFF_FFFF);             // unmapped write is dropped
    reg_rd(8'hFF);
    send_item(FuncUnused, OffStatus, 32'hFFFF_FFFF, 4'hF, 12'hFFF);
    reg_wr(OffIrqEn, 32'hFFFF_FFFF);
    reg_wr(OffSmpB, 32'h1234_5678);
    reg_rd(OffSmpA);                          // both sample time offsets alias
    reg_rd(OffStatus);

    // random traffic in bursts with random gaps
    while (sent < RandomAccesses) begin
      burst = $urandom_range(1, 40);
      if (!held && sent >= 300) begin
        // back-to-back burst into a receiver that holds off, so the pipe fills
        held = 1'b1;
        hold_seq <= hold_seq + 1;
        burst = 40;
        for (int i = 0; i < burst; i++) send_random_access();
        sent += burst;
      end else begin
        for (int i = 0; i < burst; i++) send_random_access();
        sent += burst;
        if (!paused && sent >= 700) begin
          paused = 1'b1;
          wait_drained();
        end else if ($urandom_range(0, 3) != 0) begin
          idle($urandom_range(1, 8));
        end
      end
    end

    wait_drained();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d transactions: %0d reads, %0d writes, %0d sample loads, %0d unused",
             reads_sent + writes_sent + loads_sent + unused_sent,
             reads_sent, writes_sent, loads_sent, unused_sent);
    $display("%0d results checked, with a long result-side hold-off and a full drain pause",
             results);
    if (outstanding != 0) $display("%0d expected results never arrived", outstanding);
    if (mismatches == 0 && outstanding == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl
rtl/adc_rb_pkg.sv
rtl/adc_register_block.sv
verif/adc_register_block_checker.sv
verif/tb_adc_register_block.sv
